// ----- hw/rtl/lrpr_pkg.sv -----
package lrpr_pkg;

  localparam int KIND_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int LEN_W    = 6;
  localparam int OFS_W    = 32;
  localparam int CFG_AW   = 3;

  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EOF  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EOB = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EOF = 2'd2;

  localparam logic [BYTE_W-1:0] HDR_LINE   = 8'd0;
  localparam logic [BYTE_W-1:0] HDR_OFFSET = 8'd2;
  localparam logic [BYTE_W-1:0] NEWLINE    = 8'h0A;

  // register index lives in paddr[2]
  localparam logic [0:0] REG_START_OFFSET = 1'b0;

  typedef struct packed {
    logic                accepted;
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   line_byte;
    logic                byte_valid;
    logic                last;
    logic [LEN_W-1:0]    line_length;
    logic [OFS_W-1:0]    resume_offset;
    logic [OFS_W-1:0]    replay_offset;
  } lrpr_res_t;

endpackage

// ----- hw/rtl/lrpr_if.sv -----
interface lrpr_in_if;
  logic                          valid;
  logic                          ready;
  logic [lrpr_pkg::KIND_W-1:0]   kind;
  logic [lrpr_pkg::BYTE_W-1:0]   byte_value;

  modport source (output valid, kind, byte_value, input ready);
  modport sink (input valid, kind, byte_value, output ready);
endinterface

interface lrpr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [lrpr_pkg::STATUS_W-1:0] status;
  logic [lrpr_pkg::BYTE_W-1:0]   line_byte;
  logic                          byte_valid;
  logic                          last;
  logic [lrpr_pkg::LEN_W-1:0]    line_length;
  logic [lrpr_pkg::OFS_W-1:0]    resume_offset;
  logic [lrpr_pkg::OFS_W-1:0]    replay_offset;

  modport source (output valid, accepted, status, line_byte, byte_valid, last, line_length,
                  resume_offset, replay_offset, input ready);
  modport sink (input valid, accepted, status, line_byte, byte_valid, last, line_length,
                resume_offset, replay_offset, output ready);
endinterface

// ----- hw/rtl/line_record_prefetch_ring_top.sv -----
// Line record prefetch ring, one request at a time.
// File byte: posted; a newline or end of file flushes the line into the ring.
// Read: an empty ring returns its tail status; a line is read after any offset
//   record, then one byte per cycle while the output is free: one ring memory read port.
// Sync active-low reset: empty ring, tail status end of buffer, start offset 0.
module line_record_prefetch_ring_top #(
  parameter int RING_BYTES = 4096,
  parameter int LINE_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lrpr_in_if.sink                         in_ch,
  lrpr_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [lrpr_pkg::CFG_AW-1:0]     paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import lrpr_pkg::*;

  localparam int AW = $clog2(RING_BYTES);
  localparam int PW = AW + 1;             // positions reach RING_BYTES itself
  localparam int LW = $clog2(LINE_BYTES);
  localparam int FW = LW + 1;
  localparam logic [PW:0]   RING_L   = (PW+1)'(RING_BYTES);
  localparam logic [FW-1:0] LINE_L   = FW'(LINE_BYTES);
  localparam logic [FW-1:0] LINE_MAX = FW'(LINE_BYTES - 1);

  typedef enum logic [4:0] {
    S_IDLE, S_POST, S_EMIT,
    S_F_OFF_HDR, S_F_OFF_BASE, S_F_OFF_BYTE, S_F_LINE_HDR, S_F_LEN, S_F_LBASE,
    S_F_COPY, S_F_END,
    S_R_START, S_R_HDR_ISSUE, S_R_HDR_WAIT, S_R_OFF_BASE, S_R_OFF_WAIT,
    S_R_LEN_ISSUE, S_R_LEN_WAIT, S_R_BYTE
  } state_t;

  // what the flush was started for
  typedef enum logic [1:0] { CTX_PRE, CTX_NL, CTX_EOF } ctx_t;

  // Piece placement: a piece that runs past the ring end starts at zero.
  function automatic logic [PW-1:0] place_at(input logic [PW-1:0] pos, input logic [6:0] n);
    logic [PW-1:0] res;
    res = pos;
    if (({1'b0, pos} + (PW+1)'(n)) > RING_L) res = '0;
    return res;
  endfunction

  // Space check; the writer never catches the reader from below.
  function automatic logic fits(input logic [PW-1:0] w, input logic [PW-1:0] rp,
                                input logic [6:0] n);
    logic [PW:0] e;
    logic        ok;
    e = {1'b0, w} + (PW+1)'(n);
    if (e > RING_L) ok = (rp > w) ? 1'b0 : ((PW+1)'(n) < {1'b0, rp});
    else            ok = ((w < rp) == (e < {1'b0, rp}));
    return ok;
  endfunction

  state_t        state_r, state_nxt;
  ctx_t          ctx_r, ctx_nxt;
  logic [1:0]    kind_r, kind_nxt;
  logic [7:0]    byte_r, byte_nxt;
  logic [31:0]   start_r, start_nxt;
  logic [31:0]   fp_r, fp_nxt;
  logic [31:0]   pub_r, pub_nxt;
  logic [31:0]   ro_r, ro_nxt;
  logic [31:0]   rep_r, rep_nxt;
  logic [31:0]   asm_r, asm_nxt;
  logic [PW-1:0] wp_r, wp_nxt;
  logic [PW-1:0] rp_r, rp_nxt;
  logic [PW-1:0] tail_r, tail_nxt;
  logic [PW-1:0] base_r, base_nxt;
  logic [1:0]    ts_r, ts_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic          pend_r, pend_nxt;
  logic          fok_r, fok_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic [5:0]    len_r, len_nxt;
  logic [1:0]    guard_r, guard_nxt;
  logic          em_acc_r, em_acc_nxt;
  logic [1:0]    em_st_r, em_st_nxt;
  logic          em_line_r, em_line_nxt;
  logic          out_valid_r, out_valid_nxt;
  lrpr_res_t     out_r, out_nxt;

  logic          ring_we, ring_re;
  logic [AW-1:0] ring_waddr, ring_raddr;
  logic [7:0]    ring_wdata, ring_rdata;
  logic          line_we, line_re;
  logic [LW-1:0] line_waddr, line_raddr;
  logic [7:0]    line_rdata;

  logic          out_free;
  logic          cfg_we;
  logic [PW-1:0] b;
  logic [5:0]    len_c;

  // Ring writes happen only in flush states, ring reads only in reader states,
  // line store writes only in S_POST, so no two accesses to one entry overlap.
  lrpr_mem #(.DEPTH(RING_BYTES), .WIDTH(8)) u_ring (
    .clk, .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rdata)
  );

  lrpr_mem #(.DEPTH(LINE_BYTES), .WIDTH(8)) u_line (
    .clk, .we(line_we), .waddr(line_waddr), .wdata(byte_r),
    .re(line_re), .raddr(line_raddr), .rdata(line_rdata)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign cfg_we      = psel && penable && pwrite && (paddr[2] == REG_START_OFFSET);
  assign pready      = 1'b1;
  assign prdata      = (paddr[2] == REG_START_OFFSET) ? start_r : '0;

  assign out_ch.valid         = out_valid_r;
  assign out_ch.accepted      = out_r.accepted;
  assign out_ch.status        = out_r.status;
  assign out_ch.line_byte     = out_r.line_byte;
  assign out_ch.byte_valid    = out_r.byte_valid;
  assign out_ch.last          = out_r.last;
  assign out_ch.line_length   = out_r.line_length;
  assign out_ch.resume_offset = out_r.resume_offset;
  assign out_ch.replay_offset = out_r.replay_offset;

  always_comb begin
    state_nxt = state_r;   ctx_nxt = ctx_r;     kind_nxt = kind_r;   byte_nxt = byte_r;
    start_nxt = start_r;   fp_nxt = fp_r;       pub_nxt = pub_r;     ro_nxt = ro_r;
    rep_nxt = rep_r;       asm_nxt = asm_r;     wp_nxt = wp_r;       rp_nxt = rp_r;
    tail_nxt = tail_r;     base_nxt = base_r;   ts_nxt = ts_r;       fill_nxt = fill_r;
    pend_nxt = pend_r;     fok_nxt = fok_r;     cnt_nxt = cnt_r;     len_nxt = len_r;
    guard_nxt = guard_r;   em_acc_nxt = em_acc_r; em_st_nxt = em_st_r;
    em_line_nxt = em_line_r;
    out_valid_nxt = out_valid_r;
    out_nxt = out_r;
    ring_we = 1'b0; ring_waddr = '0; ring_wdata = '0;
    ring_re = 1'b0; ring_raddr = '0;
    line_we = 1'b0; line_waddr = LW'(fill_r);
    line_re = 1'b0; line_raddr = '0;
    b = '0;
    len_c = 6'(fill_r);

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt = in_ch.kind;
          byte_nxt = in_ch.byte_value;
          case (in_ch.kind)
            KIND_READ: state_nxt = S_R_START;
            KIND_NONE: begin
              em_acc_nxt = 1'b0; em_st_nxt = ST_OK; em_line_nxt = 1'b0;
              state_nxt = S_EMIT;
            end
            default: begin
              if (pend_r) begin
                ctx_nxt = CTX_PRE; state_nxt = S_F_OFF_HDR;
              end else begin
                state_nxt = S_POST;
              end
            end
          endcase
        end
      end

      S_POST: begin
        em_acc_nxt = 1'b1; em_st_nxt = ST_OK; em_line_nxt = 1'b0;
        state_nxt = S_EMIT;
        if (kind_r == KIND_BYTE) begin
          fp_nxt = fp_r + 32'd1;
          if (byte_r == NEWLINE) begin
            fill_nxt = (fill_r >= LINE_L) ? LINE_MAX : fill_r;
            pend_nxt = 1'b1; ctx_nxt = CTX_NL; state_nxt = S_F_OFF_HDR;
          end else if (fill_r < LINE_L) begin
            line_we = 1'b1;
            fill_nxt = fill_r + FW'(1);
          end
        end else if (fill_r != '0) begin
          fill_nxt = (fill_r >= LINE_L) ? LINE_MAX : fill_r;
          pend_nxt = 1'b1; ctx_nxt = CTX_EOF; state_nxt = S_F_OFF_HDR;
        end else begin
          ts_nxt = ST_EOF;
        end
      end

      // ---- flush: offset record if the position moved, then the line record
      S_F_OFF_HDR: begin
        if (fp_r != pub_r) begin
          if (fits(wp_r, rp_r, 7'd5)) begin
            b = place_at(wp_r, 7'd1);
            ring_we = 1'b1; ring_waddr = b[AW-1:0]; ring_wdata = HDR_OFFSET;
            wp_nxt = b + PW'(1);
            state_nxt = S_F_OFF_BASE;
          end else begin
            fok_nxt = 1'b0; state_nxt = S_F_END;
          end
        end else begin
          state_nxt = S_F_LINE_HDR;
        end
      end

      S_F_OFF_BASE: begin
        b = place_at(wp_r, 7'd4);
        ring_we = 1'b1; ring_waddr = b[AW-1:0]; ring_wdata = fp_r[7:0];
        base_nxt = b; wp_nxt = b + PW'(4); cnt_nxt = 6'd1;
        state_nxt = S_F_OFF_BYTE;
      end

      S_F_OFF_BYTE: begin
        b = base_r + PW'(cnt_r);
        ring_we = 1'b1; ring_waddr = b[AW-1:0];
        ring_wdata = fp_r[8*cnt_r[1:0] +: 8];
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin
          pub_nxt = fp_r; state_nxt = S_F_LINE_HDR;
        end
      end

      S_F_LINE_HDR: begin
        if (fits(wp_r, rp_r, 7'd2 + 7'(len_c))) begin
          b = place_at(wp_r, 7'd1);
          ring_we = 1'b1; ring_waddr = b[AW-1:0]; ring_wdata = HDR_LINE;
          wp_nxt = b + PW'(1); len_nxt = len_c;
          state_nxt = S_F_LEN;
        end else begin
          fok_nxt = 1'b0; state_nxt = S_F_END;
        end
      end

      S_F_LEN: begin
        b = place_at(wp_r, 7'd1);
        ring_we = 1'b1; ring_waddr = b[AW-1:0]; ring_wdata = 8'(len_r);
        wp_nxt = b + PW'(1);
        state_nxt = S_F_LBASE;
      end

      S_F_LBASE: begin
        b = place_at(wp_r, 7'(len_r));
        base_nxt = b; wp_nxt = b + PW'(len_r); cnt_nxt = '0;
        if (len_r == '0) begin
          tail_nxt = b; ts_nxt = ST_EOB; fill_nxt = '0; pend_nxt = 1'b0;
          fok_nxt = 1'b1; state_nxt = S_F_END;
        end else begin
          line_re = 1'b1; line_raddr = '0;
          state_nxt = S_F_COPY;
        end
      end

      S_F_COPY: begin
        b = base_r + PW'(cnt_r);
        ring_we = 1'b1; ring_waddr = b[AW-1:0]; ring_wdata = line_rdata;
        if (cnt_r + 6'd1 == len_r) begin
          tail_nxt = wp_r; ts_nxt = ST_EOB; fill_nxt = '0; pend_nxt = 1'b0;
          fok_nxt = 1'b1; state_nxt = S_F_END;
        end else begin
          line_re = 1'b1; line_raddr = LW'(cnt_r + 6'd1);
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      S_F_END: begin
        em_st_nxt = ST_OK; em_line_nxt = 1'b0; state_nxt = S_EMIT;
        case (ctx_r)
          CTX_PRE: begin
            em_acc_nxt = 1'b0;
            if (fok_r) state_nxt = S_POST;
          end
          CTX_NL:  em_acc_nxt = 1'b1;
          default: begin
            em_acc_nxt = fok_r;
            if (fok_r) ts_nxt = ST_EOF;
          end
        endcase
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.accepted      = em_acc_r;
          out_nxt.status        = em_st_r;
          out_nxt.line_byte     = '0;
          out_nxt.byte_valid    = 1'b0;
          out_nxt.last          = 1'b1;
          out_nxt.line_length   = '0;
          out_nxt.resume_offset = em_line_r ? ro_r : '0;
          out_nxt.replay_offset = em_line_r ? rep_r : '0;
          state_nxt = S_IDLE;
        end
      end

      // ---- reader
      S_R_START: begin
        rep_nxt = ro_r; guard_nxt = '0;
        if (rp_r == tail_r) begin
          em_acc_nxt = 1'b1; em_st_nxt = ts_r; em_line_nxt = 1'b0;
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_R_HDR_ISSUE;
        end
      end

      S_R_HDR_ISSUE: begin
        b = place_at(rp_r, 7'd1);
        ring_re = 1'b1; ring_raddr = b[AW-1:0]; rp_nxt = b + PW'(1);
        state_nxt = S_R_HDR_WAIT;
      end

      S_R_HDR_WAIT: begin
        if (ring_rdata == HDR_OFFSET) begin
          state_nxt = S_R_OFF_BASE;
        end else if (ring_rdata == HDR_LINE) begin
          state_nxt = S_R_LEN_ISSUE;
        end else begin
          rp_nxt = tail_r;
          em_acc_nxt = 1'b1; em_st_nxt = ST_EOB; em_line_nxt = 1'b0;
          state_nxt = S_EMIT;
        end
      end

      S_R_OFF_BASE: begin
        b = place_at(rp_r, 7'd4);
        ring_re = 1'b1; ring_raddr = b[AW-1:0];
        base_nxt = b; rp_nxt = b + PW'(4); cnt_nxt = '0;
        state_nxt = S_R_OFF_WAIT;
      end

      S_R_OFF_WAIT: begin
        asm_nxt = {ring_rdata, asm_r[31:8]};
        if (cnt_r == 6'd3) begin
          ro_nxt = {ring_rdata, asm_r[31:8]};
          guard_nxt = guard_r + 2'd1;
          if (guard_r == 2'd2) begin
            // three offset records in a row: treat as corrupt
            rp_nxt = tail_r;
            em_acc_nxt = 1'b1; em_st_nxt = ST_EOB; em_line_nxt = 1'b0;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_R_HDR_ISSUE;
          end
        end else begin
          b = base_r + PW'(cnt_r + 6'd1);
          ring_re = 1'b1; ring_raddr = b[AW-1:0];
          cnt_nxt = cnt_r + 6'd1;
        end
      end

      S_R_LEN_ISSUE: begin
        b = place_at(rp_r, 7'd1);
        ring_re = 1'b1; ring_raddr = b[AW-1:0]; rp_nxt = b + PW'(1);
        state_nxt = S_R_LEN_WAIT;
      end

      S_R_LEN_WAIT: begin
        len_nxt = ring_rdata[5:0];
        b = place_at(rp_r, 7'(ring_rdata[5:0]));
        base_nxt = b; rp_nxt = b + PW'(ring_rdata[5:0]); cnt_nxt = '0;
        if (ring_rdata[5:0] == '0) begin
          em_acc_nxt = 1'b1; em_st_nxt = ST_OK; em_line_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          ring_re = 1'b1; ring_raddr = b[AW-1:0];
          state_nxt = S_R_BYTE;
        end
      end

      S_R_BYTE: begin
        if (out_free) begin
          out_valid_nxt         = 1'b1;
          out_nxt.accepted      = 1'b1;
          out_nxt.status        = ST_OK;
          out_nxt.line_byte     = ring_rdata;
          out_nxt.byte_valid    = 1'b1;
          out_nxt.last          = (cnt_r + 6'd1 == len_r);
          out_nxt.line_length   = len_r;
          out_nxt.resume_offset = ro_r;
          out_nxt.replay_offset = rep_r;
          if (cnt_r + 6'd1 == len_r) begin
            state_nxt = S_IDLE;
          end else begin
            b = base_r + PW'(cnt_r + 6'd1);
            ring_re = 1'b1; ring_raddr = b[AW-1:0];
            cnt_nxt = cnt_r + 6'd1;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // user must write config only while idle (not enforced); loading start also loads position
    if (cfg_we) begin
      start_nxt = pwdata;
      fp_nxt    = pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= '0;
      fp_r        <= '0;
      pub_r       <= '0;
      ro_r        <= '0;
      wp_r        <= '0;
      rp_r        <= '0;
      tail_r      <= '0;
      ts_r        <= ST_EOB;
      fill_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      fp_r        <= fp_nxt;
      pub_r       <= pub_nxt;
      ro_r        <= ro_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      tail_r      <= tail_nxt;
      ts_r        <= ts_nxt;
      fill_r      <= fill_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ctx_r     <= ctx_nxt;
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    rep_r     <= rep_nxt;
    asm_r     <= asm_nxt;
    base_r    <= base_nxt;
    fok_r     <= fok_nxt;
    cnt_r     <= cnt_nxt;
    len_r     <= len_nxt;
    guard_r   <= guard_nxt;
    em_acc_r  <= em_acc_nxt;
    em_st_r   <= em_st_nxt;
    em_line_r <= em_line_nxt;
    out_r     <= out_nxt;
  end

  // ring memory is never written and read in the same cycle
  a_ring_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(ring_we && ring_re)) else $error("ring write and read overlap");

  // a pending line is always cropped to fit a length byte
  a_pend_fill: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (fill_r < LINE_L)) else $error("pending line too long");

  // line store writes stay inside the store
  a_line_wr: assert property (@(posedge clk) disable iff (!rst_n)
    line_we |-> (fill_r < LINE_L)) else $error("line store overrun");

  // positions never pass the ring end
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, wp_r} <= RING_L) && ({1'b0, rp_r} <= RING_L))
    else $error("ring position out of range");

endmodule

// ----- hw/rtl/lrpr_mem.sv -----
module lrpr_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
